// ===== sv/fpnm_pkg.sv =====
// shared types for the fixed point neuron multiply-accumulate
`timescale 1ns / 1ps

package fpnm_pkg;

    // control that moves one word from the input register into the accumulator
    typedef struct packed {
        logic fire;
        logic last;
    } t_step;

endpackage

// ===== sv/fpnm_product.sv =====
// product of activation and weight with range check and floor shift
`timescale 1ns / 1ps

module fpnm_product #(
    parameter int DATA_BITS = 16,
    parameter int FRAC_BITS = 5
) (
    input  logic signed [DATA_BITS-1:0] i_activation,
    input  logic signed [DATA_BITS-1:0] i_weight,
    output logic signed [DATA_BITS-1:0] o_term,
    output logic                        o_overflow
);

    localparam int PROD_W = 2 * DATA_BITS;
    localparam int EXT_W  = 2 * DATA_BITS + FRAC_BITS + 1;
    localparam logic signed [EXT_W-1:0] P_LIM = EXT_W'(1) << (DATA_BITS - 1 + FRAC_BITS);
    localparam logic signed [EXT_W-1:0] N_LIM = -P_LIM;

    logic signed [PROD_W-1:0] prod;
    logic signed [EXT_W-1:0]  prod_ext;
    logic signed [PROD_W-1:0] prod_shr;

    assign prod       = i_activation * i_weight;
    assign prod_ext   = EXT_W'(prod);
    assign prod_shr   = prod >>> FRAC_BITS;
    assign o_term     = prod_shr[DATA_BITS-1:0];
    assign o_overflow = (prod_ext >= P_LIM) || (prod_ext <= N_LIM);

endmodule

// ===== sv/fpnm_accum.sv =====
// accumulator and sticky overflow flag, bias add on the last term
`timescale 1ns / 1ps

module fpnm_accum #(
    parameter int DATA_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fpnm_pkg::t_step             i_step,
    input  logic signed [DATA_BITS-1:0] i_term,
    input  logic                        i_term_ovf,
    input  logic signed [DATA_BITS-1:0] i_bias,
    output logic signed [DATA_BITS-1:0] o_value,
    output logic                        o_overflow
);

    localparam int SUM_W = DATA_BITS + 1;
    localparam logic signed [SUM_W-1:0] S_LIM = SUM_W'(1) << (DATA_BITS - 1);
    localparam logic signed [SUM_W-1:0] N_LIM = -S_LIM;

    logic signed [DATA_BITS-1:0] r_acc, n_acc;
    logic                        r_seen, n_seen;

    logic signed [SUM_W-1:0]     sum_term;
    logic signed [SUM_W-1:0]     sum_bias;
    logic                        sum_term_ovf;
    logic                        sum_bias_ovf;
    logic signed [DATA_BITS-1:0] acc_mid;
    logic                        seen_mid;
    logic                        seen_end;

    assign sum_term     = SUM_W'(r_acc) + SUM_W'(i_term);
    assign sum_term_ovf = (sum_term >= S_LIM) || (sum_term <= N_LIM);
    assign seen_mid     = r_seen || i_term_ovf || sum_term_ovf;
    assign acc_mid      = seen_mid ? r_acc : sum_term[DATA_BITS-1:0];

    assign sum_bias     = SUM_W'(acc_mid) + SUM_W'(i_bias);
    assign sum_bias_ovf = (sum_bias >= S_LIM) || (sum_bias <= N_LIM);
    assign seen_end     = seen_mid || sum_bias_ovf;

    assign o_overflow   = seen_end;
    assign o_value      = seen_end ? '0 : sum_bias[DATA_BITS-1:0];

    always_comb begin
        n_acc  = r_acc;
        n_seen = r_seen;
        if (i_step.fire) begin
            if (i_step.last) begin
                n_acc  = '0;
                n_seen = 1'b0;
            end else begin
                n_acc  = acc_mid;
                n_seen = seen_mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_seen <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_seen <= n_seen;
        end
    end

endmodule

// ===== sv/fixed_point_neuron_mac.sv =====
// top level of the fixed point neuron multiply-accumulate
`timescale 1ns / 1ps

// One neuron of a fully connected layer in signed fixed point. Each word on the
// slave stream carries an activation, a weight and a bias; tlast marks the
// final term of the neuron, and only then is the bias added. Each term's
// product is range checked, floor shifted by FRAC_BITS and added to a
// DATA_BITS accumulator with a range check. A word on the master stream is
// sent for each last term only: tdata holds the neuron value and tuser the
// sticky overflow flag; the value is 0 when the flag is set.
// A word is registered on input, worked out in one pass of the
// multiplier and two adders, and lands in the output register.
// Throughput: one word per cycle unless a stalled result holds a last term,
// set by the single multiply-add pass against the accumulator register.
// Reset (synchronous, active low) clears the accumulator, the flag and both
// valid registers. When the master side stalls with a result waiting, a
// following last term holds in the input register; terms that are not last
// still pass into the accumulator, and the slave side fills only when both
// registers are held.
module fixed_point_neuron_mac #(
    parameter int DATA_BITS = 16,
    parameter int FRAC_BITS = 5,
    localparam int IN_W  = ((3 * DATA_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((DATA_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // activation, weight, bias from bit 0 up, zero padded to bytes
    input  logic [IN_W-1:0]      i_s_axis_tdata,
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // neuron_value from bit 0, zero padded to bytes
    output logic [OUT_W-1:0]     o_m_axis_tdata,
    // overflow
    output logic                 o_m_axis_tuser
);

    logic                        r_in_valid, n_in_valid;
    logic signed [DATA_BITS-1:0] r_act;
    logic signed [DATA_BITS-1:0] r_wgt;
    logic signed [DATA_BITS-1:0] r_bias;
    logic                        r_last;

    logic                        r_out_valid, n_out_valid;
    logic signed [DATA_BITS-1:0] r_out_value;
    logic                        r_out_ovf;

    logic                        out_free;
    logic                        in_take;
    fpnm_pkg::t_step             step;

    logic signed [DATA_BITS-1:0] term;
    logic                        term_ovf;
    logic signed [DATA_BITS-1:0] res_value;
    logic                        res_ovf;

    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign step.fire = r_in_valid && (!r_last || out_free);
    assign step.last = r_last;
    assign o_s_axis_tready = !r_in_valid || step.fire;
    assign in_take   = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (step.fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (step.fire && r_last) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_act  <= i_s_axis_tdata[DATA_BITS-1:0];
            r_wgt  <= i_s_axis_tdata[2*DATA_BITS-1:DATA_BITS];
            r_bias <= i_s_axis_tdata[3*DATA_BITS-1:2*DATA_BITS];
            r_last <= i_s_axis_tlast;
        end
        if (step.fire && r_last) begin
            r_out_value <= res_value;
            r_out_ovf   <= res_ovf;
        end
    end

    fpnm_product #(
        .DATA_BITS(DATA_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_product (
        .i_activation(r_act),
        .i_weight    (r_wgt),
        .o_term      (term),
        .o_overflow  (term_ovf)
    );

    fpnm_accum #(
        .DATA_BITS(DATA_BITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_term    (term),
        .i_term_ovf(term_ovf),
        .i_bias    (r_bias),
        .o_value   (res_value),
        .o_overflow(res_ovf)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'($unsigned(r_out_value));
    assign o_m_axis_tuser  = r_out_ovf;

    // overflowed neuron reports zero
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (r_out_value == '0))
        else $error("overflow result with nonzero value");

    // clean result never reaches the most negative code
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
        (r_out_value != {1'b1, {(DATA_BITS-1){1'b0}}}))
        else $error("result out of symmetric range");

    // last term always leaves a result word behind
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step.fire && r_last) |=> r_out_valid)
        else $error("last term produced no result");

    // held input word is not lost while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step.fire) |=> (r_in_valid && $stable(r_last)))
        else $error("held input word dropped");

endmodule
